@@ hw/rtl/indexed_list_insert_delete_defines.svh @@
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Shared concurrent assertion forms used by the indexed list checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILID_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ilid_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list package
// Field widths, operation and status codes, and controller-to-datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int FUNC_W      = 3;
    localparam int POS_W       = 16;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    localparam int IN_FIELDS_W  = FUNC_W + POS_W + VALUE_W;
    localparam int OUT_FIELDS_W = VALUE_W + STATUS_W + COUNT_OUT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_HEAD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TAIL   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Source of the result's read value.
    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_ONES,
        RSEL_RAM
    } t_rsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_val;
        logic                rd_en;
        logic                mv_en;
        logic                put_en;
        logic                emit;
        t_rsel               rsel;
        logic [STATUS_W-1:0] status;
    } t_dp_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/ilid_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ilid_ctrl.sv @@
// ----------------------------------------------------------------------------
// Indexed list controller
// Decodes each request and sequences reads, entry moves and the final write.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ctrl #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF,
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ilid_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [ilid_pkg::POS_W-1:0]    i_pos,
    input  wire logic                          i_out_free,
    output ilid_pkg::t_dp_ctl                  o_ctl,
    output logic      [ADDR_W-1:0]             o_rd_addr,
    output logic      [ADDR_W-1:0]             o_wr_addr,
    output logic      [CNT_W-1:0]              o_count
);

    import ilid_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOVE,
        S_DRAIN,
        S_PUT,
        S_EMIT
    } t_state;

    t_state              r_state,  n_state;
    logic [ADDR_W-1:0]   r_idx,    n_idx;
    logic [ADDR_W-1:0]   r_end,    n_end;
    logic                r_dir_up, n_dir_up;
    logic                r_put,    n_put;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    t_rsel               r_rsel,   n_rsel;

    logic              pos_neg;
    logic [CMP_W-1:0]  pos_mag;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  ins_pos;
    logic              full;
    logic              rd_hit;
    logic [ADDR_W-1:0] src;

    assign pos_neg = i_pos[POS_W-1];
    assign pos_mag = CMP_W'(i_pos[POS_W-2:0]);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign rd_hit  = !pos_neg && (pos_mag < cnt_ext);

    // Head inserts at zero, tail at the length, a negative position clamps to zero.
    always_comb begin
        unique case (i_func) inside
            FN_HEAD: ins_pos = '0;
            FN_TAIL: ins_pos = cnt_ext;
            default: ins_pos = pos_neg ? '0 : pos_mag;
        endcase
    end

    // Insert moves entries up, walking down; delete moves them down, walking up.
    assign src = r_dir_up ? r_idx + ADDR_W'(1) : r_idx - ADDR_W'(1);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_end    = r_end;
        n_dir_up = r_dir_up;
        n_put    = r_put;
        n_count  = r_count;
        n_status = r_status;
        n_rsel   = r_rsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_EMIT;
                    n_rsel   = RSEL_ZERO;
                    n_status = ST_RANGE;
                    n_put    = 1'b0;
                    unique case (i_func) inside
                        FN_READ: begin
                            if (rd_hit) begin
                                n_idx    = ADDR_W'(pos_mag);
                                n_rsel   = RSEL_RAM;
                                n_status = ST_DONE;
                                n_state  = S_RD;
                            end else begin
                                n_rsel = RSEL_ONES;
                            end
                        end
                        FN_HEAD, FN_TAIL, FN_INSERT: begin
                            if (ins_pos > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_DONE;
                                n_count  = r_count + CNT_W'(1);
                                n_idx    = ADDR_W'(cnt_ext);
                                n_end    = ADDR_W'(ins_pos);
                                n_dir_up = 1'b0;
                                n_put    = 1'b1;
                                n_state  = (ins_pos == cnt_ext) ? S_PUT : S_MOVE;
                            end
                        end
                        FN_DELETE: begin
                            if (rd_hit) begin
                                n_status = ST_DONE;
                                n_count  = r_count - CNT_W'(1);
                                n_idx    = ADDR_W'(pos_mag);
                                n_end    = ADDR_W'(cnt_ext - CMP_W'(1));
                                n_dir_up = 1'b1;
                                n_state  = (pos_mag + CMP_W'(1) == cnt_ext) ? S_EMIT : S_MOVE;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_MOVE: begin
                n_idx = src;
                if (src == r_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_put ? S_PUT : S_EMIT;
            end
            S_PUT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_end    <= '0;
            r_dir_up <= 1'b0;
            r_put    <= 1'b0;
            r_count  <= '0;
            r_status <= ST_DONE;
            r_rsel   <= RSEL_ZERO;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_end    <= n_end;
            r_dir_up <= n_dir_up;
            r_put    <= n_put;
            r_count  <= n_count;
            r_status <= n_status;
            r_rsel   <= n_rsel;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_ctl.load_val = i_in_valid && (r_state == S_IDLE);
    assign o_ctl.rd_en    = (r_state == S_RD) || (r_state == S_MOVE);
    assign o_ctl.mv_en    = (r_state == S_MOVE);
    assign o_ctl.put_en   = (r_state == S_PUT);
    assign o_ctl.emit     = (r_state == S_EMIT) && i_out_free;
    assign o_ctl.rsel     = r_rsel;
    assign o_ctl.status   = r_status;
    assign o_rd_addr      = (r_state == S_RD) ? r_idx : src;
    assign o_wr_addr      = (r_state == S_PUT) ? r_end : r_idx;
    assign o_count        = r_count;

endmodule

`default_nettype wire

@@ hw/rtl/ilid_dp.sv @@
// ----------------------------------------------------------------------------
// Indexed list datapath
// Entry memory, one-deep move pipeline, held insert value and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_dp #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF,
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire ilid_pkg::t_dp_ctl                    i_ctl,
    input  wire logic        [ADDR_W-1:0]             i_rd_addr,
    input  wire logic        [ADDR_W-1:0]             i_wr_addr,
    input  wire logic        [CNT_W-1:0]              i_count,
    input  wire logic signed [ilid_pkg::VALUE_W-1:0]  i_value,
    output logic                                      o_out_free,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed      [ilid_pkg::VALUE_W-1:0]  o_read_value,
    output logic             [ilid_pkg::STATUS_W-1:0] o_status,
    output logic          [ilid_pkg::COUNT_OUT_W-1:0] o_count_after
);

    import ilid_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic                      r_mv_valid;
    logic [ADDR_W-1:0]         r_mv_dst;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_read_value;
    logic [STATUS_W-1:0]       r_status;
    logic [COUNT_OUT_W-1:0]    r_count_after;

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [VALUE_W-1:0]        wdata;
    logic [VALUE_W-1:0]        rdata;
    logic signed [VALUE_W-1:0] rd_sel;

    // A move writes the entry read in the previous cycle one place over.
    assign we    = r_mv_valid || i_ctl.put_en;
    assign waddr = r_mv_valid ? r_mv_dst : i_wr_addr;
    assign wdata = r_mv_valid ? rdata : r_value;

    ilid_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        unique case (i_ctl.rsel)
            RSEL_RAM:  rd_sel = rdata;
            RSEL_ONES: rd_sel = '1;
            default:   rd_sel = '0;
        endcase
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_val) begin
            r_value <= i_value;
        end
        r_mv_dst <= i_wr_addr;
        if (i_ctl.emit) begin
            r_read_value  <= rd_sel;
            r_status      <= i_ctl.status;
            r_count_after <= COUNT_OUT_W'(i_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mv_valid <= i_ctl.mv_en;
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_count_after = r_count_after;

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// Indexed list with insert and delete by position
// Ordered list of signed 32-bit values held in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the slave stream (func, position, item_value) and each
// one gives exactly one result transaction on the master stream (read_value,
// status, count_after). The block works on one request at a time; s_axis
// tready is high only while the controller is idle.
// The time a request takes grows with k, the number of entries that must
// move: the entry memory has a single write port, so an insert or a
// delete moves one entry per cycle, and k can reach CAPACITY - 1.
// Reset empties the list at once; the memory itself is never cleared, since
// only entries below the count are ever read.
// A finished result sits in an output register. While the receiver stalls,
// a new request is still accepted and processed, and only its result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Request stream.
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Fields from bit 0: func[2:0], position[18:3], item_value[50:19], zero pad.
    input  wire logic [ilid_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // Result stream.
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // Fields from bit 0: read_value[31:0], status[33:32], count_after[42:34],
    // zero pad.
    output logic      [ilid_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    import ilid_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Unpacked request fields.
    logic [FUNC_W-1:0]         in_func;
    logic [POS_W-1:0]          in_pos;
    logic signed [VALUE_W-1:0] in_value;

    assign in_func  = i_s_axis_tdata[FUNC_W-1:0];
    assign in_pos   = i_s_axis_tdata[FUNC_W +: POS_W];
    assign in_value = i_s_axis_tdata[FUNC_W + POS_W +: VALUE_W];

    // Controller to datapath commands and addresses.
    t_dp_ctl           ctl;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  count;
    logic              out_free;

    // Result fields out of the datapath's output register.
    logic signed [VALUE_W-1:0] out_read_value;
    logic [STATUS_W-1:0]       out_status;
    logic [COUNT_OUT_W-1:0]    out_count_after;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_func     (in_func),
        .i_pos      (in_pos),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_count    (count)
    );

    ilid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_count       (count),
        .i_value       (in_value),
        .o_out_free    (out_free),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_read_value  (out_read_value),
        .o_status      (out_status),
        .o_count_after (out_count_after)
    );

    // Pack the result with read_value in the lowest bits.
    assign o_m_axis_tdata = {
        {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
        out_count_after,
        out_status,
        out_read_value
    };

endmodule

`default_nettype wire

@@ hw/rtl/ilid_checker.sv @@
// ----------------------------------------------------------------------------
// Indexed list port checker
// Watches the top level's streams and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_delete_defines.svh"

module ilid_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_valid,
    input  wire logic                              i_s_ready,
    input  wire logic                              i_m_valid,
    input  wire logic                              i_m_ready,
    input  wire logic [ilid_pkg::OUT_TDATA_W-1:0]  i_m_data
);

    import ilid_pkg::*;

    logic                   in_txn;
    logic [STATUS_W-1:0]    out_status;
    logic                   out_stall;
    logic                   out_hold;
    logic                   out_full;
    logic                   read_zero;
    logic                   status_ok;
    logic [OUT_TDATA_W-1:0] r_last_data;

    // Result word seen at the previous edge, for the stall check.
    always_ff @(posedge i_clk) begin
        r_last_data <= i_m_data;
    end

    assign in_txn     = i_s_valid && i_s_ready;
    assign out_status = i_m_data[VALUE_W +: STATUS_W];
    assign out_stall  = i_m_valid && !i_m_ready;
    assign out_hold   = i_m_valid && (i_m_data == r_last_data);
    assign out_full   = i_m_valid && (out_status == ST_FULL);
    assign read_zero  = (i_m_data[VALUE_W-1:0] == '0);
    assign status_ok  = (out_status == ST_DONE) || (out_status == ST_RANGE) ||
                        (out_status == ST_FULL);

    // Requests are handled one at a time, so ready drops after each transaction.
    `ILID_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_txn, !i_s_ready, "second request taken")

    // A stalled result holds its value.
    `ILID_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, out_stall, out_hold, "result changed")

    // A valid result's status field never carries the unused code.
    `ILID_ASSERT_SAME(a_status_legal, i_clk, i_rst_n, i_m_valid, status_ok, "illegal status code")

    // A dropped insert is never a read, so its read value is zero.
    `ILID_ASSERT_SAME(a_full_no_data, i_clk, i_rst_n, out_full, read_zero, "full with read data")

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (i_s_axis_tvalid),
    .i_s_ready (o_s_axis_tready),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list testbench
// Sends read, insert and delete requests to the list and checks every result
// transaction against a queue-based model of the list kept in this file.
// ----------------------------------------------------------------------------

module tb;

    import ilid_pkg::*;

    // The block is built with its default capacity.
    localparam int LIST_CAPACITY = CAPACITY_DEF;

    // Function codes that the block does not implement; they must be ignored.
    localparam logic [FUNC_W-1:0] FN_UNKNOWN_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNKNOWN_HI = 3'd7;

    // Items per random phase, and the end-of-run quiet time. The longest
    // request is an insert at the head of a nearly full list, so the drain
    // time and the watchdog are set well above the time it needs.
    localparam int RANDOM_ITEMS   = 470;
    localparam int DRAIN_CYCLES   = LIST_CAPACITY + 50;
    localparam int WATCHDOG_LIMIT = 16 * LIST_CAPACITY;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic [VALUE_W-1:0]     read_value;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count_after;
    } list_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] rsp_data;

    // Model of the list contents, head at index 0, and the results that the
    // accepted requests are expected to produce, oldest first.
    logic [VALUE_W-1:0] list_model[$];
    list_result_t       pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned stall_cycles  = 0;

    // 12 ns clock period.
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    indexed_list_insert_delete dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data)
    );

    // Applies one request to the list model and returns the result that the
    // block must give for it. A negative insert position is taken as the
    // head. For an insert, a position past the length is reported as out of
    // range even when the list is also full.
    function automatic list_result_t apply_request(input logic [FUNC_W-1:0] fn,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic [VALUE_W-1:0] val);
        list_result_t res;
        int           len;
        int           slot;
        len             = list_model.size();
        res.read_value  = '0;
        res.status      = ST_RANGE;
        case (fn)
            FN_READ: begin
                if (pos >= 0 && pos < len) begin
                    slot           = pos;
                    res.read_value = list_model[slot];
                    res.status     = ST_DONE;
                end else begin
                    res.read_value = '1;
                end
            end
            FN_HEAD, FN_TAIL, FN_INSERT: begin
                if (fn == FN_HEAD) begin
                    slot = 0;
                end else if (fn == FN_TAIL) begin
                    slot = len;
                end else begin
                    slot = (pos < 0) ? 0 : int'(pos);
                end
                if (slot > len) begin
                    res.status = ST_RANGE;
                end else if (len >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_model.insert(slot, val);
                    res.status = ST_DONE;
                end
            end
            FN_DELETE: begin
                if (pos >= 0 && pos < len) begin
                    slot = pos;
                    list_model.delete(slot);
                    res.status = ST_DONE;
                end
            end
            default: begin
            end
        endcase
        res.count_after = COUNT_OUT_W'(list_model.size());
        return res;
    endfunction

    // Offers one request on the request stream, after a random number of
    // idle cycles, and records its expected result once it is accepted.
    // The valid line is left high after acceptance so that back-to-back
    // requests keep it asserted without a glitch.
    task automatic issue_request(input logic [FUNC_W-1:0] fn,
                                 input logic signed [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] val);
        logic [IN_TDATA_W-1:0] word;
        word                              = '0;
        word[FUNC_W-1:0]                  = fn;
        word[FUNC_W +: POS_W]             = pos;
        word[FUNC_W + POS_W +: VALUE_W]   = val;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= word;
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        pending_results.push_back(apply_request(fn, pos, val));
    endtask

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Requests on an empty list: reads and deletes miss, an insert past
    // the length is ignored, and unknown function codes do nothing.
    task automatic test_empty_list();
        issue_request(FN_READ, 16'sd0, 32'h1234_5678);
        issue_request(FN_READ, -16'sd32768, 32'h0);
        issue_request(FN_DELETE, 16'sd0, 32'h0);
        issue_request(FN_DELETE, -16'sd1, 32'hFFFF_FFFF);
        issue_request(FN_INSERT, 16'sd1, 32'hDEAD_BEEF);
        issue_request(FN_UNKNOWN_LO, 16'sd0, 32'hA5A5_A5A5);
        issue_request(FN_UNKNOWN_HI, 16'sd32767, 32'h5A5A_5A5A);
    endtask

    // Builds a short list with every kind of insert, reads it back, then
    // deletes from the middle, the tail and the head.
    task automatic test_ordered_edits();
        issue_request(FN_HEAD, 16'sd0, 32'h8000_0000);
        issue_request(FN_TAIL, 16'sd0, 32'h7FFF_FFFF);
        // Negative position is clamped to the head.
        issue_request(FN_INSERT, -16'sd32768, 32'hFFFF_FFFF);
        // Position equal to the length appends.
        issue_request(FN_INSERT, 16'sd3, 32'h0000_0000);
        issue_request(FN_INSERT, 16'sd2, 32'h5555_5555);
        // Position past the length is ignored.
        issue_request(FN_INSERT, 16'sd32767, 32'hAAAA_AAAA);
        for (int idx = 0; idx < 6; idx++) begin
            issue_request(FN_READ, POS_W'(idx), 32'h0);
        end
        issue_request(FN_READ, 16'sd32767, 32'h0);
        issue_request(FN_DELETE, 16'sd2, 32'h0);
        issue_request(FN_DELETE, 16'sd3, 32'h0);
        issue_request(FN_DELETE, 16'sd0, 32'h0);
        issue_request(FN_DELETE, 16'sd2, 32'h0);
        issue_request(FN_READ, 16'sd1, 32'h0);
    endtask

    // Fills the list to capacity, then tries every insert on the full list
    // and works at both ends of it.
    task automatic test_full_list();
        while (list_model.size() < LIST_CAPACITY) begin
            issue_request(FN_TAIL, POS_W'($urandom), $urandom);
        end
        issue_request(FN_HEAD, 16'sd0, $urandom);
        issue_request(FN_TAIL, 16'sd0, $urandom);
        issue_request(FN_INSERT, 16'sd1, $urandom);
        issue_request(FN_INSERT, POS_W'(LIST_CAPACITY), $urandom);
        // Out of range wins over full.
        issue_request(FN_INSERT, POS_W'(LIST_CAPACITY + 1), $urandom);
        issue_request(FN_READ, POS_W'(LIST_CAPACITY - 1), 32'h0);
        issue_request(FN_READ, POS_W'(LIST_CAPACITY), 32'h0);
        issue_request(FN_DELETE, 16'sd0, 32'h0);
        issue_request(FN_DELETE, POS_W'(LIST_CAPACITY - 2), 32'h0);
        issue_request(FN_READ, 16'sd0, 32'h0);
    endtask

    // Random traffic that sweeps the list between empty and full. The
    // request mix leans toward inserts while the list grows and toward
    // deletes while it shrinks, and it lingers a little at both ends so that
    // full-list inserts and empty-list deletes happen often.
    task automatic test_random_traffic(input int unsigned n_items);
        logic [FUNC_W-1:0]       fn;
        logic signed [POS_W-1:0] pos;
        int                      len;
        int unsigned             roll;
        bit                      growing;
        growing = 1'b1;
        for (int unsigned item = 0; item < n_items; item++) begin
            len = list_model.size();
            if (len >= LIST_CAPACITY && $urandom_range(0, 7) == 0) begin
                growing = 1'b0;
            end else if (len == 0 && $urandom_range(0, 3) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                growing = !growing;
            end

            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                fn = FUNC_W'($urandom_range(FN_UNKNOWN_LO, FN_UNKNOWN_HI));
            end else if (roll < 24) begin
                fn = FN_READ;
            end else if (roll < (growing ? 84 : 39)) begin
                case ($urandom_range(0, 2))
                    0:       fn = FN_HEAD;
                    1:       fn = FN_TAIL;
                    default: fn = FN_INSERT;
                endcase
            end else begin
                fn = FN_DELETE;
            end

            // Mostly valid positions, some right at the edges of the list,
            // and some fully random ones that are nearly always out of range.
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                pos = POS_W'($urandom_range(0, len));
            end else if (roll < 85) begin
                case ($urandom_range(0, 3))
                    0:       pos = '0;
                    1:       pos = POS_W'(len - 1);
                    2:       pos = POS_W'(len);
                    default: pos = POS_W'(len + 1);
                endcase
            end else begin
                pos = POS_W'($urandom);
            end

            issue_request(fn, pos, $urandom);
        end
    endtask

    // Result side: checks each result transaction against the oldest
    // expectation and then picks the ready level for the next cycle. The
    // values read here are those from before the edge, so the check sees
    // exactly what the block saw at the handshake.
    task automatic report_field(input string name,
                                input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        list_result_t want;
        list_result_t got;
        if (rst_n && rsp_valid && rsp_ready) begin
            got.read_value  = rsp_data[VALUE_W-1:0];
            got.status      = rsp_data[VALUE_W +: STATUS_W];
            got.count_after = rsp_data[VALUE_W + STATUS_W +: COUNT_OUT_W];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction, expected none, actual 0x%0h",
                         $time, rsp_data);
            end else begin
                want = pending_results.pop_front();
                report_field("read_value", want.read_value, got.read_value);
                report_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
                report_field("count_after", VALUE_W'(want.count_after),
                             VALUE_W'(got.count_after));
            end
        end
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: ends the run if neither stream completes a transaction for
    // too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence: reset once, directed tests, then random traffic under
    // three idle patterns (sender idles less than the receiver, the other
    // way round, and no idling at all).
    initial begin
        set_idle(21, 52);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_ordered_edits();
        test_full_list();

        test_random_traffic(RANDOM_ITEMS);
        set_idle(52, 21);
        test_random_traffic(RANDOM_ITEMS);
        set_idle(0, 0);
        test_random_traffic(RANDOM_ITEMS);

        // Stop sending, wait for every expected result, then give the block
        // time to show any stray result.
        req_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ indexed_list_insert_delete.f @@
+incdir+hw/rtl
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_ram.sv
hw/rtl/ilid_ctrl.sv
hw/rtl/ilid_dp.sv
hw/rtl/indexed_list_insert_delete.sv
hw/rtl/ilid_checker.sv
tb/tb.sv
